// File: rtl/core/snoc_pkg.sv
package snoc_pkg;

   localparam int MAX_GRID_WIDTH  = 256;
   localparam int MAX_GRID_HEIGHT = 256;

   localparam int COL_W  = $clog2(MAX_GRID_WIDTH);
   localparam int ROW_W  = $clog2(MAX_GRID_HEIGHT);
   localparam int ADDR_W = COL_W + ROW_W;

   localparam int CELL_W    = 12;
   localparam int POS_W     = 8;
   localparam int CFG_DIM_W = 9;
   localparam int RING_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RINGS   = 2'd2;

   localparam logic [CFG_DIM_W-1:0] GRID_WIDTH_RESET  = 9'd256;
   localparam logic [CFG_DIM_W-1:0] GRID_HEIGHT_RESET = 9'd256;
   localparam logic [RING_W-1:0]    MAX_RINGS_RESET   = 8'd50;

   localparam logic CMD_SET  = 1'b0;
   localparam logic CMD_FIND = 1'b1;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] cols;
      logic [CFG_DIM_W-1:0] rows;
      logic [RING_W-1:0]    max_rings;
   } cfg_type;

   typedef struct packed {
      logic clear;
      logic write_cell;
      logic start;
      logic step;
      logic capture;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hit;
      logic exhausted;
   } dp_status_type;

endpackage

// File: rtl/core/snoc_req_if.sv
interface snoc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 command;
   logic signed [snoc_pkg::CELL_W-1:0]   cell_x;
   logic signed [snoc_pkg::CELL_W-1:0]   cell_y;
   logic                                 occupied;

   modport source (output valid, command, cell_x, cell_y, occupied, input ready);
   modport sink   (input valid, command, cell_x, cell_y, occupied, output ready);
endinterface

// File: rtl/core/snoc_rsp_if.sv
interface snoc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [snoc_pkg::POS_W-1:0]   found_x;
   logic [snoc_pkg::POS_W-1:0]   found_y;

   modport source (output valid, found, found_x, found_y, input ready);
   modport sink   (input valid, found, found_x, found_y, output ready);
endinterface

// File: rtl/core/snoc_csr_if.sv
interface snoc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [snoc_pkg::CSR_IDX_W-1:0]   index;
   logic [snoc_pkg::CSR_DAT_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/snoc_csr.sv
module snoc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_valid,
   input  logic [snoc_pkg::CSR_IDX_W-1:0]   wr_index,
   input  logic [snoc_pkg::CSR_DAT_W-1:0]   wr_data,
   output snoc_pkg::cfg_type                cfg
);

   logic [snoc_pkg::CFG_DIM_W-1:0] grid_width_ff;
   logic [snoc_pkg::CFG_DIM_W-1:0] grid_height_ff;
   logic [snoc_pkg::RING_W-1:0]    max_rings_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= snoc_pkg::GRID_WIDTH_RESET;
         grid_height_ff <= snoc_pkg::GRID_HEIGHT_RESET;
         max_rings_ff   <= snoc_pkg::MAX_RINGS_RESET;
      end else if (wr_valid) begin
         unique case (wr_index)
            snoc_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= wr_data;
            snoc_pkg::CSR_GRID_HEIGHT: grid_height_ff <= wr_data;
            snoc_pkg::CSR_MAX_RINGS:   max_rings_ff   <= wr_data[snoc_pkg::RING_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the grid to the size of the map
   always_comb begin
      cfg.cols = (int'(grid_width_ff) > snoc_pkg::MAX_GRID_WIDTH)
               ? snoc_pkg::CFG_DIM_W'(snoc_pkg::MAX_GRID_WIDTH) : grid_width_ff;
      cfg.rows = (int'(grid_height_ff) > snoc_pkg::MAX_GRID_HEIGHT)
               ? snoc_pkg::CFG_DIM_W'(snoc_pkg::MAX_GRID_HEIGHT) : grid_height_ff;
      cfg.max_rings = max_rings_ff;
   end

endmodule

// File: rtl/core/snoc_datapath.sv
module snoc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  snoc_pkg::cfg_type                   cfg,
   input  snoc_pkg::dp_cmd_type                cmd,
   output snoc_pkg::dp_status_type             status,
   input  logic signed [snoc_pkg::CELL_W-1:0]  cell_x,
   input  logic signed [snoc_pkg::CELL_W-1:0]  cell_y,
   input  logic                                occupied,
   output logic                                found,
   output logic [snoc_pkg::POS_W-1:0]          found_x,
   output logic [snoc_pkg::POS_W-1:0]          found_y
);

   localparam int COORD_W   = snoc_pkg::CELL_W + 1;
   localparam int MEM_DEPTH = 2 ** snoc_pkg::ADDR_W;
   localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(1);

   typedef enum logic [1:0] {
      HEAD_SOUTH,
      HEAD_EAST,
      HEAD_NORTH,
      HEAD_WEST
   } heading_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   function automatic logic in_grid(coord_type x, coord_type y,
                                    logic [snoc_pkg::CFG_DIM_W-1:0] cols,
                                    logic [snoc_pkg::CFG_DIM_W-1:0] rows);
      coord_type cols_s;
      coord_type rows_s;
      cols_s = $signed({{(COORD_W-snoc_pkg::CFG_DIM_W){1'b0}}, cols});
      rows_s = $signed({{(COORD_W-snoc_pkg::CFG_DIM_W){1'b0}}, rows});
      return !x[COORD_W-1] && !y[COORD_W-1] && (x < cols_s) && (y < rows_s);
   endfunction

   function automatic logic [snoc_pkg::ADDR_W-1:0] cell_addr(coord_type x, coord_type y);
      return {x[snoc_pkg::COL_W-1:0], y[snoc_pkg::ROW_W-1:0]};
   endfunction

   logic mem [MEM_DEPTH];

   logic [snoc_pkg::ADDR_W-1:0] clear_addr_ff;
   logic [snoc_pkg::ADDR_W-1:0] wr_addr;
   logic                        wr_en;
   logic                        wr_bit;
   logic                        rd_bit_ff;

   coord_type   req_x;
   coord_type   req_y;
   coord_type   start_x_ff, start_x_in;
   coord_type   start_y_ff, start_y_in;
   coord_type   walk_x_ff, walk_x_in;
   coord_type   walk_y_ff, walk_y_in;
   coord_type   ring_s;
   logic [snoc_pkg::RING_W-1:0] ring_ff, ring_in;
   heading_type heading_ff, heading_in;
   logic        more_rings;

   logic        probe_valid_ff;
   logic        probe_in_grid_ff;
   coord_type   probe_x_ff;
   coord_type   probe_y_ff;
   logic        hit;

   logic                        res_found_ff;
   logic [snoc_pkg::POS_W-1:0]  res_x_ff;
   logic [snoc_pkg::POS_W-1:0]  res_y_ff;
   logic                        found_ff;
   logic [snoc_pkg::POS_W-1:0]  found_x_ff;
   logic [snoc_pkg::POS_W-1:0]  found_y_ff;

   assign req_x = $signed({{(COORD_W-snoc_pkg::CELL_W){cell_x[snoc_pkg::CELL_W-1]}}, cell_x});
   assign req_y = $signed({{(COORD_W-snoc_pkg::CELL_W){cell_y[snoc_pkg::CELL_W-1]}}, cell_y});
   assign ring_s = $signed({{(COORD_W-snoc_pkg::RING_W){1'b0}}, ring_ff});
   assign more_rings = ring_ff < cfg.max_rings;

   // clear sweep has the write port, then set beats
   always_comb begin
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_bit  = 1'b0;
      end else begin
         wr_en   = cmd.write_cell && in_grid(req_x, req_y, cfg.cols, cfg.rows);
         wr_addr = cell_addr(req_x, req_y);
         wr_bit  = occupied;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_bit;
      end
      rd_bit_ff <= mem[cell_addr(walk_x_ff, walk_y_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   // spiral walker: holds the next cell to probe
   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      walk_x_in  = walk_x_ff;
      walk_y_in  = walk_y_ff;
      ring_in    = ring_ff;
      heading_in = heading_ff;
      if (cmd.start) begin
         start_x_in = req_x;
         start_y_in = req_y;
         walk_x_in  = req_x;
         walk_y_in  = req_y;
         ring_in    = '0;
         heading_in = HEAD_SOUTH;
      end else if (cmd.step && more_rings) begin
         unique case (heading_ff)
            HEAD_SOUTH: begin
               if (walk_y_ff - COORD_ONE < start_y_ff - ring_s) begin
                  heading_in = HEAD_EAST;
                  ring_in    = ring_ff + 1'b1;
               end else begin
                  walk_y_in = walk_y_ff - COORD_ONE;
               end
            end
            HEAD_EAST: begin
               if (walk_x_ff + COORD_ONE > start_x_ff + ring_s) begin
                  heading_in = HEAD_NORTH;
               end else begin
                  walk_x_in = walk_x_ff + COORD_ONE;
               end
            end
            HEAD_NORTH: begin
               if (walk_y_ff + COORD_ONE > start_y_ff + ring_s) begin
                  heading_in = HEAD_WEST;
               end else begin
                  walk_y_in = walk_y_ff + COORD_ONE;
               end
            end
            HEAD_WEST: begin
               if (walk_x_ff - COORD_ONE < start_x_ff - ring_s) begin
                  heading_in = HEAD_SOUTH;
               end else begin
                  walk_x_in = walk_x_ff - COORD_ONE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      start_x_ff <= start_x_in;
      start_y_ff <= start_y_in;
      walk_x_ff  <= walk_x_in;
      walk_y_ff  <= walk_y_in;
      ring_ff    <= ring_in;
      heading_ff <= heading_in;
   end

   // probe stage lines up with the registered map read
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_valid_ff <= 1'b0;
      end else begin
         probe_valid_ff <= cmd.step && more_rings;
      end
      probe_in_grid_ff <= in_grid(walk_x_ff, walk_y_ff, cfg.cols, cfg.rows);
      probe_x_ff       <= walk_x_ff;
      probe_y_ff       <= walk_y_ff;
   end

   assign hit = probe_valid_ff && probe_in_grid_ff && rd_bit_ff;

   always_comb begin
      status.clear_last = &clear_addr_ff;
      status.hit        = hit;
      status.exhausted  = !probe_valid_ff && !more_rings;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_found_ff <= hit;
         res_x_ff     <= hit ? probe_x_ff[snoc_pkg::POS_W-1:0] : '0;
         res_y_ff     <= hit ? probe_y_ff[snoc_pkg::POS_W-1:0] : '0;
      end
      if (cmd.load_out) begin
         found_ff   <= res_found_ff;
         found_x_ff <= res_x_ff;
         found_y_ff <= res_y_ff;
      end
   end

   assign found   = found_ff;
   assign found_x = found_x_ff;
   assign found_y = found_y_ff;

endmodule

// File: rtl/core/snoc_ctrl.sv
module snoc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_command,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output snoc_pkg::dp_cmd_type     cmd,
   input  snoc_pkg::dp_status_type  status
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start      = (req_command == snoc_pkg::CMD_FIND);
               cmd.write_cell = (req_command == snoc_pkg::CMD_SET);
            end
         end
         ST_WALK: begin
            if (status.hit || status.exhausted) begin
               cmd.capture = 1'b1;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_EMIT: cmd.load_out = out_free;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: if (status.clear_last) state_ff <= ST_IDLE;
            ST_IDLE:  if (cmd.start) state_ff <= ST_WALK;
            ST_WALK:  if (cmd.capture) state_ff <= ST_EMIT;
            ST_EMIT:  if (cmd.load_out) state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/core/spiral_nearest_occupied_cell.sv
// channel   dir   handshake     payload
// req_port  in    valid/ready   command, cell_x, cell_y, occupied
// rsp_port  out   valid/ready   found, found_x, found_y
// csr_port  in    valid/ready   index, data
//
// a set beat gives no response beat
// a find probes one cell per cycle along the spiral through the registered map read,
// 4*r*r - 2*r - 1 probes for r rings with no hit,
// 9899 at 50 rings, 259589 at 255 rings
// after reset the map is swept clear, one cell a cycle over all 2**ADDR_W (65536) cells,
// with req_ready low; csr writes are taken at all times
// a waiting response holds its beat; the next request is taken while it waits
module spiral_nearest_occupied_cell (
   input  logic       clock,
   input  logic       reset,
   snoc_req_if.sink   req_port,
   snoc_rsp_if.source rsp_port,
   snoc_csr_if.sink   csr_port
);

   snoc_pkg::cfg_type       cfg;
   snoc_pkg::dp_cmd_type    cmd;
   snoc_pkg::dp_status_type status;

   assign csr_port.ready = 1'b1;

   snoc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_port.valid),
      .wr_index (csr_port.index),
      .wr_data  (csr_port.data),
      .cfg      (cfg)
   );

   snoc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_port.valid),
      .req_command (req_port.command),
      .req_ready   (req_port.ready),
      .rsp_valid   (rsp_port.valid),
      .rsp_ready   (rsp_port.ready),
      .cmd         (cmd),
      .status      (status)
   );

   snoc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .status   (status),
      .cell_x   (req_port.cell_x),
      .cell_y   (req_port.cell_y),
      .occupied (req_port.occupied),
      .found    (rsp_port.found),
      .found_x  (rsp_port.found_x),
      .found_y  (rsp_port.found_y)
   );

endmodule

// File: test/tb.sv
module tb;

   // register index with no register behind it
   localparam logic [snoc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {HEAD_SOUTH, HEAD_EAST, HEAD_NORTH, HEAD_WEST} heading_type;

   typedef struct packed {
      logic                       found;
      logic [snoc_pkg::POS_W-1:0] x;
      logic [snoc_pkg::POS_W-1:0] y;
   } answer_type;

   typedef struct packed {
      logic                               is_reg;
      logic                               command;
      logic signed [snoc_pkg::CELL_W-1:0] x;
      logic signed [snoc_pkg::CELL_W-1:0] y;
      logic                               occupied;
      logic [snoc_pkg::CSR_IDX_W-1:0]     idx;
      logic [snoc_pkg::CSR_DAT_W-1:0]     data;
      logic                               known;
      answer_type                         golden;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;

   snoc_req_if req_bus ();
   snoc_rsp_if rsp_bus ();
   snoc_csr_if csr_bus ();

   spiral_nearest_occupied_cell dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #30000000;
      $display("spiral_nearest_occupied_cell regression: fail");
      $finish;
   end

   // local copy of the block's map and registers
   bit occ_bits [snoc_pkg::MAX_GRID_WIDTH*snoc_pkg::MAX_GRID_HEIGHT];
   int cols_cfg = 256;
   int rows_cfg = 256;
   int rings_cfg = 50;

   answer_type awaited[$];
   int         bad_beats = 0;
   int         n_sets = 0;
   int         n_finds = 0;
   int         n_hits = 0;
   int         n_regs = 0;
   bit         req_steady = 1'b0;
   bit         rsp_steady = 1'b0;
   int         rsp_hold = 0;

   function automatic bit cell_live(int cx, int cy);
      int wlim;
      int hlim;
      wlim = (cols_cfg > snoc_pkg::MAX_GRID_WIDTH) ? snoc_pkg::MAX_GRID_WIDTH : cols_cfg;
      hlim = (rows_cfg > snoc_pkg::MAX_GRID_HEIGHT) ? snoc_pkg::MAX_GRID_HEIGHT : rows_cfg;
      return cx >= 0 && cx < wlim && cy >= 0 && cy < hlim;
   endfunction

   function automatic int cell_addr(int cx, int cy);
      return cx * snoc_pkg::MAX_GRID_HEIGHT + cy;
   endfunction

   function automatic answer_type spiral_lookup(int sx, int sy);
      answer_type  ans;
      heading_type heading;
      int          ring;
      int          cx;
      int          cy;
      ans = '0;
      heading = HEAD_SOUTH;
      ring = 0;
      cx = sx;
      cy = sy;
      while (!ans.found && ring < rings_cfg) begin
         if (cell_live(cx, cy) && occ_bits[cell_addr(cx, cy)]) begin
            ans.found = 1'b1;
            ans.x = cx[snoc_pkg::POS_W-1:0];
            ans.y = cy[snoc_pkg::POS_W-1:0];
         end
         // overshooting the ring bound undoes the step and turns
         case (heading)
            HEAD_EAST: begin
               cx++;
               if (cx > sx + ring) begin
                  cx--;
                  heading = HEAD_NORTH;
               end
            end
            HEAD_NORTH: begin
               cy++;
               if (cy > sy + ring) begin
                  cy--;
                  heading = HEAD_WEST;
               end
            end
            HEAD_WEST: begin
               cx--;
               if (cx < sx - ring) begin
                  cx++;
                  heading = HEAD_SOUTH;
               end
            end
            default: begin
               cy--;
               if (cy < sy - ring) begin
                  cy++;
                  heading = HEAD_EAST;
                  ring++;
               end
            end
         endcase
      end
      return ans;
   endfunction

   function automatic script_row_type beat_row(logic cmd, int x, int y, logic occ);
      script_row_type r;
      r = '0;
      r.command = cmd;
      r.x = x[snoc_pkg::CELL_W-1:0];
      r.y = y[snoc_pkg::CELL_W-1:0];
      r.occupied = occ;
      return r;
   endfunction

   function automatic script_row_type known_row(int x, int y, logic hit, int fx, int fy);
      script_row_type r;
      r = beat_row(snoc_pkg::CMD_FIND, x, y, 1'b0);
      r.known = 1'b1;
      r.golden.found = hit;
      r.golden.x = fx[snoc_pkg::POS_W-1:0];
      r.golden.y = fy[snoc_pkg::POS_W-1:0];
      return r;
   endfunction

   function automatic script_row_type reg_row(logic [snoc_pkg::CSR_IDX_W-1:0] idx, int val);
      script_row_type r;
      r = '0;
      r.is_reg = 1'b1;
      r.idx = idx;
      r.data = val[snoc_pkg::CSR_DAT_W-1:0];
      return r;
   endfunction

   // entered and left at a falling edge; valid stays high on return
   task automatic send_beat(input logic cmd, input logic signed [snoc_pkg::CELL_W-1:0] x,
                            input logic signed [snoc_pkg::CELL_W-1:0] y, input logic occ,
                            input bit known, input answer_type golden);
      int         gap;
      answer_type ans;
      gap = req_steady ? 0 : int'($urandom_range(0, 12));
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.cell_x   <= x;
      req_bus.cell_y   <= y;
      req_bus.occupied <= occ;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (cmd == snoc_pkg::CMD_SET) begin
         if (cell_live(int'(x), int'(y)))
            occ_bits[cell_addr(int'(x), int'(y))] = occ;
         n_sets++;
      end else begin
         ans = known ? golden : spiral_lookup(int'(x), int'(y));
         awaited.insert(awaited.size(), ans);
         n_finds++;
      end
      @(negedge clock);
   endtask

   // leaves csr valid high; the caller lowers it after the last write
   task automatic write_reg(input logic [snoc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [snoc_pkg::CSR_DAT_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         snoc_pkg::CSR_GRID_WIDTH:  cols_cfg = int'(val);
         snoc_pkg::CSR_GRID_HEIGHT: rows_cfg = int'(val);
         snoc_pkg::CSR_MAX_RINGS:   rings_cfg = int'(val[snoc_pkg::RING_W-1:0]);
         default: ;
      endcase
      n_regs++;
      @(negedge clock);
   endtask

   // wait for every awaited answer, then let a trailing set finish
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (awaited.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic load_grid(input int w, input int h, input int r);
      settle();
      write_reg(snoc_pkg::CSR_GRID_WIDTH, w[snoc_pkg::CSR_DAT_W-1:0]);
      write_reg(snoc_pkg::CSR_GRID_HEIGHT, h[snoc_pkg::CSR_DAT_W-1:0]);
      write_reg(snoc_pkg::CSR_MAX_RINGS, r[snoc_pkg::CSR_DAT_W-1:0]);
      csr_bus.valid <= 1'b0;
   endtask

   // response side: the stall counts down only while a beat is offered
   always @(negedge clock) begin
      if (rsp_hold > 0 && rsp_bus.valid === 1'b1)
         rsp_hold--;
      rsp_bus.ready <= (rsp_hold == 0);
   end

   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.found = rsp_bus.found;
         got.x = rsp_bus.found_x;
         got.y = rsp_bus.found_y;
         rsp_hold = rsp_steady ? 0 : int'($urandom_range(0, 12));
         if (got.found === 1'b1)
            n_hits++;
         if (awaited.size() == 0) begin
            bad_beats++;
            if (bad_beats <= 10)
               $display("%0t: unexpected response beat found=%b x=%0d y=%0d",
                        $realtime, got.found, got.x, got.y);
         end else begin
            want = awaited[0];
            awaited.delete(0);
            if (got.found !== want.found || got.x !== want.x || got.y !== want.y) begin
               bad_beats++;
               if (bad_beats <= 10)
                  $display("%0t: mismatch: expected %b/%0d/%0d got %b/%0d/%0d",
                           $realtime, want.found, want.x, want.y,
                           got.found, got.x, got.y);
            end
         end
      end
   end

   initial begin
      script_row_type script[$];
      script_row_type row;
      bit             prev_reg;
      int             phase;
      int             item;
      int             pick;
      int             w;
      int             h;
      int             wx;
      int             wy;
      int             off_x;
      int             off_y;
      logic           cmd;
      logic [snoc_pkg::CELL_W-1:0] rx;
      logic [snoc_pkg::CELL_W-1:0] ry;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = snoc_pkg::CMD_SET;
      req_bus.cell_x = '0;
      req_bus.cell_y = '0;
      req_bus.occupied = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = snoc_pkg::CSR_GRID_WIDTH;
      csr_bus.data = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      script = '{
         known_row(0, 0, 1'b0, 0, 0),                          // empty map after reset
         beat_row(snoc_pkg::CMD_SET, 5, 5, 1'b1),
         reg_row(snoc_pkg::CSR_MAX_RINGS, 0),
         known_row(5, 5, 1'b0, 0, 0),                          // ring limit zero
         reg_row(snoc_pkg::CSR_MAX_RINGS, 1),
         known_row(5, 5, 1'b1, 5, 5),
         known_row(-2048, -2048, 1'b0, 0, 0),
         beat_row(snoc_pkg::CMD_SET, 255, 255, 1'b1),
         beat_row(snoc_pkg::CMD_SET, 0, 0, 1'b1),
         beat_row(snoc_pkg::CMD_SET, 2047, 2047, 1'b1),        // outside the grid
         beat_row(snoc_pkg::CMD_SET, -2048, 0, 1'b1),
         beat_row(snoc_pkg::CMD_SET, 0, -1, 1'b1),
         reg_row(snoc_pkg::CSR_MAX_RINGS, 255),
         known_row(255, 255, 1'b1, 255, 255),
         beat_row(snoc_pkg::CMD_FIND, -20, -20, 1'b0),
         beat_row(snoc_pkg::CMD_FIND, -1, -1, 1'b0),
         beat_row(snoc_pkg::CMD_FIND, 300, 200, 1'b0),
         reg_row(snoc_pkg::CSR_GRID_WIDTH, 511),               // above the maximum
         reg_row(snoc_pkg::CSR_GRID_HEIGHT, 511),
         beat_row(snoc_pkg::CMD_FIND, 250, 250, 1'b0),
         reg_row(snoc_pkg::CSR_MAX_RINGS, 3),
         reg_row(snoc_pkg::CSR_GRID_WIDTH, 0),                 // no cell in the grid
         beat_row(snoc_pkg::CMD_SET, 1, 1, 1'b1),
         known_row(0, 0, 1'b0, 0, 0),
         reg_row(snoc_pkg::CSR_GRID_WIDTH, 1),
         reg_row(snoc_pkg::CSR_GRID_HEIGHT, 1),
         known_row(0, 0, 1'b1, 0, 0),
         beat_row(snoc_pkg::CMD_FIND, 255, 255, 1'b0),         // shrunk grid hides far cell
         beat_row(snoc_pkg::CMD_FIND, 3, 0, 1'b0),
         reg_row(snoc_pkg::CSR_GRID_WIDTH, 256),
         reg_row(snoc_pkg::CSR_GRID_HEIGHT, 256),
         known_row(255, 255, 1'b1, 255, 255),                  // far cell counts again
         beat_row(snoc_pkg::CMD_SET, 255, 255, 1'b0),
         beat_row(snoc_pkg::CMD_FIND, 255, 255, 1'b0),
         reg_row(CSR_UNUSED, 511),
         known_row(5, 5, 1'b1, 5, 5)
      };

      prev_reg = 1'b0;
      foreach (script[i]) begin
         row = script[i];
         if (row.is_reg) begin
            if (!prev_reg)
               settle();
            write_reg(row.idx, row.data);
         end else begin
            csr_bus.valid <= 1'b0;
            send_beat(row.command, row.x, row.y, row.occupied, row.known, row.golden);
         end
         prev_reg = row.is_reg;
      end

      // random phases: sets and finds clustered around a window, some noise
      for (phase = 0; phase < 5; phase++) begin
         w = (phase == 4) ? int'($urandom_range(257, 511)) : int'($urandom_range(1, 256));
         h = int'($urandom_range(1, 256));
         load_grid(w, h, (phase == 0) ? 50 : int'($urandom_range(2, 20)));
         req_steady = (phase == 1);
         rsp_steady = (phase == 3);
         wx = int'($urandom_range(0, ((w > 256) ? 256 : w) - 1));
         wy = int'($urandom_range(0, h - 1));
         for (item = 0; item < 16; item++) begin
            pick = int'($urandom_range(0, 99));
            off_x = int'($urandom_range(0, 16));
            off_y = int'($urandom_range(0, 16));
            if (pick < 10) begin
               cmd = 1'($urandom_range(0, 1));
               rx = snoc_pkg::CELL_W'($urandom);
               ry = snoc_pkg::CELL_W'($urandom);
               send_beat(cmd, rx, ry, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else if (pick < 60) begin
               send_beat(snoc_pkg::CMD_SET,
                         snoc_pkg::CELL_W'(wx + off_x / 2 - 4),
                         snoc_pkg::CELL_W'(wy + off_y / 2 - 4),
                         $urandom_range(0, 3) != 0, 1'b0, '0);
            end else begin
               send_beat(snoc_pkg::CMD_FIND,
                         snoc_pkg::CELL_W'(wx + off_x - 8),
                         snoc_pkg::CELL_W'(wy + off_y - 8),
                         1'($urandom_range(0, 1)), 1'b0, '0);
            end
            if ($urandom_range(0, 19) == 0)
               settle();
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (awaited.size() != 0) begin
         bad_beats++;
         $display("%0d find answers never arrived", awaited.size());
      end
      $display("covered %0d set beats and %0d find beats (%0d answered with a hit),",
               n_sets, n_finds, n_hits);
      $display("%0d register writes over the directed script and 5 random grid setups",
               n_regs);
      if (bad_beats == 0) begin
         $display("spiral_nearest_occupied_cell regression: pass");
      end else begin
         $display("%0d response mismatches", bad_beats);
         $display("spiral_nearest_occupied_cell regression: fail");
      end
      $finish;
   end

endmodule
